### rtl/core/lbe_pkg.sv
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared types and constants of the layer eviction block: transaction
// structs, operation codes, register indexes and controller/datapath links.
// ----------------------------------------------------------------------------
package lbe_pkg;

   localparam int OP_W      = 3;
   localparam int SLOT_W    = 5;
   localparam int BYTES_W   = 40;
   localparam int TOT_W     = 46;
   localparam int THR_W     = 17;
   localparam int PROD_W    = TOT_W + THR_W;
   localparam int CSR_IDX_W = 1;

   // operation codes
   localparam logic [OP_W-1:0] OP_REGISTER   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNREGISTER = 3'd1;
   localparam logic [OP_W-1:0] OP_ACCESS     = 3'd2;
   localparam logic [OP_W-1:0] OP_RELOAD     = 3'd3;
   localparam logic [OP_W-1:0] OP_EVICT      = 3'd4;
   localparam logic [OP_W-1:0] OP_TICK       = 3'd5;

   // result kinds
   localparam logic KIND_EVICT  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MEMORY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'd1;

   localparam logic [TOT_W-1:0] MAX_MEMORY_RESET = 46'd8589934592;
   localparam logic [THR_W-1:0] THRESHOLD_RESET  = 17'd52429;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [SLOT_W-1:0]  slot;
      logic [BYTES_W-1:0] layer_bytes;
      logic [TOT_W-1:0]   target_free;
   } lbe_req_type;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot_out;
      logic              ok;
      logic [TOT_W-1:0]  resident_bytes;
      logic [TOT_W-1:0]  evicted_bytes;
      logic              last;
   } lbe_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic reg_slot;
      logic unreg_slot;
      logic reload_slot;
      logic tgt_max;
      logic tgt_req;
      logic ev_init;
      logic ev_step;
      logic ev_latch;
      logic size_sel_ev;
      logic ev_commit;
      logic rd_prev;
      logic rm_init;
      logic rm_step;
      logic rm_done;
      logic fr_init;
      logic fr_step;
      logic fr_done;
      logic emit_final;
      logic final_ok;
   } lbe_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            slot_free;
      logic            slot_used;
      logic            slot_evicted;
      logic            over;
      logic            tfree_le_max;
      logic            res_gt_tgt;
      logic            i_zero;
      logic            i_eq_len;
      logic            ev_hit;
      logic            out_free;
   } lbe_status_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNREG,
      ST_RELOAD,
      ST_PRESS,
      ST_EV_ADDR,
      ST_EV_LIST,
      ST_EV_SIZE,
      ST_EV_CHK,
      ST_RM_RD,
      ST_RM_WR,
      ST_FR_INIT,
      ST_FR_RD,
      ST_FR_WR,
      ST_FIN_ONE,
      ST_FIN_ZERO,
      ST_FIN_TGT
   } lbe_state_type;

endpackage

### rtl/core/lbe_ram.sv
// ----------------------------------------------------------------------------
// lbe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

### rtl/core/lbe_ctrl.sv
// ----------------------------------------------------------------------------
// lbe_ctrl
// Sequencer of the eviction block: decodes the operation and steps the
// datapath through list removal, front insert and eviction walks.
// ----------------------------------------------------------------------------
module lbe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lbe_pkg::lbe_status_type status,
   output lbe_pkg::lbe_cmd_type    cmd
);
   import lbe_pkg::*;

   lbe_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (status.op)
               OP_REGISTER:   state_in = status.slot_free ? ST_PRESS : ST_FIN_ZERO;
               OP_UNREGISTER: state_in = status.slot_used ? ST_UNREG : ST_FIN_ZERO;
               OP_ACCESS:     state_in = status.slot_used ? ST_RM_RD : ST_FIN_ZERO;
               OP_RELOAD: begin
                  state_in = (status.slot_used && status.slot_evicted) ? ST_RELOAD
                                                                     : ST_FIN_ZERO;
               end
               OP_EVICT:      state_in = status.tfree_le_max ? ST_EV_ADDR : ST_FIN_ZERO;
               OP_TICK:       state_in = ST_PRESS;
               default:       state_in = ST_FIN_ZERO;
            endcase
         end
         ST_UNREG:  state_in = ST_RM_RD;
         ST_RELOAD: state_in = ST_FIN_ONE;
         ST_PRESS:  state_in = status.over ? ST_EV_ADDR : ST_FIN_ONE;
         ST_EV_ADDR: begin
            if (status.i_zero || !status.res_gt_tgt) begin
               state_in = (status.op == OP_REGISTER) ? ST_FIN_ONE : ST_FIN_TGT;
            end else begin
               state_in = ST_EV_LIST;
            end
         end
         ST_EV_LIST: state_in = ST_EV_SIZE;
         ST_EV_SIZE: state_in = ST_EV_CHK;
         ST_EV_CHK: begin
            if (!status.ev_hit || status.out_free) state_in = ST_EV_ADDR;
         end
         ST_RM_RD: begin
            if (status.i_eq_len) begin
               state_in = (status.op == OP_ACCESS) ? ST_FR_INIT : ST_FIN_ONE;
            end else begin
               state_in = ST_RM_WR;
            end
         end
         ST_RM_WR:   state_in = ST_RM_RD;
         ST_FR_INIT: state_in = ST_FR_RD;
         ST_FR_RD:   state_in = status.i_zero ? ST_FIN_ONE : ST_FR_WR;
         ST_FR_WR:   state_in = ST_FR_RD;
         ST_FIN_ONE, ST_FIN_ZERO, ST_FIN_TGT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            cmd.latch_req = req_valid;
         end
         ST_DECODE: begin
            case (status.op)
               OP_REGISTER: cmd.reg_slot = status.slot_free;
               OP_ACCESS:   cmd.rm_init  = status.slot_used;
               OP_EVICT: begin
                  cmd.tgt_req = status.tfree_le_max;
                  cmd.ev_init = status.tfree_le_max;
               end
               default: ;
            endcase
         end
         ST_UNREG: begin
            cmd.unreg_slot = 1'b1;
            cmd.rm_init    = 1'b1;
         end
         ST_RELOAD: cmd.reload_slot = 1'b1;
         ST_PRESS: begin
            cmd.tgt_max = status.over;
            cmd.ev_init = status.over;
         end
         ST_EV_ADDR: begin
            cmd.rd_prev = 1'b1;
            cmd.ev_step = !(status.i_zero || !status.res_gt_tgt);
         end
         ST_EV_LIST: cmd.ev_latch = 1'b1;
         ST_EV_SIZE: cmd.size_sel_ev = 1'b1;
         ST_EV_CHK: begin
            cmd.size_sel_ev = 1'b1;
            cmd.ev_commit   = status.ev_hit && status.out_free;
         end
         ST_RM_RD: cmd.rm_done = status.i_eq_len;
         ST_RM_WR: cmd.rm_step = 1'b1;
         ST_FR_INIT: cmd.fr_init = 1'b1;
         ST_FR_RD: begin
            cmd.rd_prev = 1'b1;
            cmd.fr_done = status.i_zero;
         end
         ST_FR_WR: cmd.fr_step = 1'b1;
         ST_FIN_ONE: begin
            cmd.emit_final = status.out_free;
            cmd.final_ok   = 1'b1;
         end
         ST_FIN_ZERO: begin
            cmd.emit_final = status.out_free;
            cmd.final_ok   = 1'b0;
         end
         ST_FIN_TGT: begin
            cmd.emit_final = status.out_free;
            cmd.final_ok   = !status.res_gt_tgt;
         end
         default: ;
      endcase
   end

endmodule

### rtl/core/lbe_dp.sv
// ----------------------------------------------------------------------------
// lbe_dp
// Datapath of the eviction block: slot flags, size and recency memories,
// byte totals, pressure product and the result register.
// ----------------------------------------------------------------------------
module lbe_dp #(
   parameter int LAYERS    = 32,
   parameter int SIZE_BITS = 40
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lbe_pkg::lbe_req_type            req_payload,
   input  logic                            csr_valid,
   input  logic [lbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lbe_pkg::TOT_W-1:0]       csr_data,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output lbe_pkg::lbe_rsp_type            rsp_payload,
   input  lbe_pkg::lbe_cmd_type            cmd,
   output lbe_pkg::lbe_status_type         status
);
   import lbe_pkg::*;

   localparam int IDX_W = $clog2(LAYERS);
   localparam int CNT_W = $clog2(LAYERS + 1);

   // request and configuration registers
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [SIZE_BITS-1:0] bytes_ff, bytes_in;
   logic [TOT_W-1:0]     tfree_ff, tfree_in;
   logic [TOT_W-1:0]     max_ff, max_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [PROD_W-1:0]    product_ff, product_in;

   // state
   logic [LAYERS-1:0]    used_ff, used_in;
   logic [LAYERS-1:0]    evd_ff, evd_in;
   logic [TOT_W-1:0]     resident_ff, resident_in;
   logic [TOT_W-1:0]     evicted_ff, evicted_in;
   logic [TOT_W-1:0]     target_ff, target_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     j_ff, j_in;
   logic [CNT_W-1:0]     len_clamp;
   logic [SLOT_W-1:0]    ev_slot_ff, ev_slot_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   lbe_rsp_type          rsp_ff, rsp_in;

   // memory ports
   logic                 list_we;
   logic [IDX_W-1:0]     list_waddr, list_raddr;
   logic [SLOT_W-1:0]    list_wdata, list_rdata;
   logic [IDX_W-1:0]     size_raddr;
   logic [SIZE_BITS-1:0] size_rdata;
   logic [TOT_W-1:0]     size_ext;

   logic                 in_range, ev_in_range, out_free;
   logic [IDX_W-1:0]     slot_idx, ev_idx;

   assign in_range    = (32'(slot_ff) < 32'(LAYERS));
   assign ev_in_range = (32'(ev_slot_ff) < 32'(LAYERS));
   assign slot_idx    = in_range ? IDX_W'(slot_ff) : '0;
   assign ev_idx      = ev_in_range ? IDX_W'(ev_slot_ff) : '0;
   assign size_ext    = TOT_W'(size_rdata);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign len_clamp   = (len_ff >= CNT_W'(LAYERS)) ? CNT_W'(LAYERS - 1) : len_ff;

   // recency list memory
   assign list_raddr = cmd.rd_prev ? IDX_W'(i_ff - 1'b1) : IDX_W'(i_ff);
   assign list_we    = (cmd.rm_step && (list_rdata != slot_ff)) || cmd.fr_step || cmd.fr_done;
   assign list_waddr = cmd.rm_step ? IDX_W'(j_ff) : (cmd.fr_step ? IDX_W'(i_ff) : '0);
   assign list_wdata = cmd.fr_done ? slot_ff : list_rdata;

   lbe_ram #(.WIDTH(SLOT_W), .DEPTH(LAYERS)) u_list_ram (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   // slot size memory
   assign size_raddr = cmd.size_sel_ev ? ev_idx : slot_idx;

   lbe_ram #(.WIDTH(SIZE_BITS), .DEPTH(LAYERS)) u_size_ram (
      .clock (clock),
      .we    (cmd.reg_slot),
      .waddr (slot_idx),
      .wdata (bytes_ff),
      .raddr (size_raddr),
      .rdata (size_rdata)
   );

   // next values
   always_comb begin
      op_in        = op_ff;
      slot_in      = slot_ff;
      bytes_in     = bytes_ff;
      tfree_in     = tfree_ff;
      max_in       = max_ff;
      thr_in       = thr_ff;
      product_in   = PROD_W'(thr_ff) * PROD_W'(max_ff);
      used_in      = used_ff;
      evd_in       = evd_ff;
      resident_in  = resident_ff;
      evicted_in   = evicted_ff;
      target_in    = target_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ev_slot_in   = ev_slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // request capture
      if (cmd.latch_req) begin
         op_in    = req_payload.operation;
         slot_in  = req_payload.slot;
         bytes_in = SIZE_BITS'(req_payload.layer_bytes);
         tfree_in = req_payload.target_free;
      end

      // configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_MAX_MEMORY: max_in = csr_data;
            CSR_THRESHOLD:  thr_in = THR_W'(csr_data);
            default: ;
         endcase
      end

      // slot bookkeeping
      if (cmd.reg_slot) begin
         used_in[slot_idx] = 1'b1;
         evd_in[slot_idx]  = 1'b0;
         resident_in       = resident_ff + TOT_W'(bytes_ff);
      end
      if (cmd.unreg_slot) begin
         if (evd_ff[slot_idx]) begin
            evicted_in = evicted_ff - size_ext;
         end else begin
            resident_in = resident_ff - size_ext;
         end
         used_in[slot_idx] = 1'b0;
         evd_in[slot_idx]  = 1'b0;
      end
      if (cmd.reload_slot) begin
         evd_in[slot_idx] = 1'b0;
         resident_in      = resident_ff + size_ext;
         evicted_in       = evicted_ff - size_ext;
      end

      // eviction walk
      if (cmd.tgt_max) target_in = max_ff;
      if (cmd.tgt_req) target_in = max_ff - tfree_ff;
      if (cmd.ev_init) i_in = len_ff;
      if (cmd.ev_step) i_in = i_ff - 1'b1;
      if (cmd.ev_latch) ev_slot_in = list_rdata;
      if (cmd.ev_commit) begin
         evd_in[ev_idx] = 1'b1;
         resident_in    = resident_ff - size_ext;
         evicted_in     = evicted_ff + size_ext;
      end

      // list removal by compaction
      if (cmd.rm_init) begin
         i_in = '0;
         j_in = '0;
      end
      if (cmd.rm_step) begin
         if (list_rdata != slot_ff) j_in = j_ff + 1'b1;
         i_in = i_ff + 1'b1;
      end
      if (cmd.rm_done) len_in = j_ff;

      // front insert by shifting down
      if (cmd.fr_init) begin
         i_in   = len_clamp;
         len_in = len_clamp;
      end
      if (cmd.fr_step) i_in = i_ff - 1'b1;
      if (cmd.fr_done) len_in = len_ff + 1'b1;

      // result register
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.ev_commit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.kind           = KIND_EVICT;
         rsp_in.slot_out       = ev_slot_ff;
         rsp_in.ok             = 1'b1;
         rsp_in.resident_bytes = resident_in;
         rsp_in.evicted_bytes  = evicted_in;
         rsp_in.last           = 1'b0;
      end
      if (cmd.emit_final) begin
         rsp_valid_in          = 1'b1;
         rsp_in.kind           = KIND_STATUS;
         rsp_in.slot_out       = slot_ff;
         rsp_in.ok             = cmd.final_ok;
         rsp_in.resident_bytes = resident_ff;
         rsp_in.evicted_bytes  = evicted_ff;
         rsp_in.last           = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= MAX_MEMORY_RESET;
         thr_ff       <= THRESHOLD_RESET;
         used_ff      <= '0;
         evd_ff       <= '0;
         resident_ff  <= '0;
         evicted_ff   <= '0;
         len_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         thr_ff       <= thr_in;
         used_ff      <= used_in;
         evd_ff       <= evd_in;
         resident_ff  <= resident_in;
         evicted_ff   <= evicted_in;
         len_ff       <= len_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      slot_ff    <= slot_in;
      bytes_ff   <= bytes_in;
      tfree_ff   <= tfree_in;
      product_ff <= product_in;
      target_ff  <= target_in;
      ev_slot_ff <= ev_slot_in;
      rsp_ff     <= rsp_in;
   end

   // status to the controller
   always_comb begin
      status.op           = op_ff;
      status.slot_free    = in_range && !used_ff[slot_idx];
      status.slot_used    = in_range && used_ff[slot_idx];
      status.slot_evicted = evd_ff[slot_idx];
      status.over         = (max_ff != '0) && ({1'b0, resident_ff, 16'b0} > product_ff);
      status.tfree_le_max = (tfree_ff <= max_ff);
      status.res_gt_tgt   = (resident_ff > target_ff);
      status.i_zero       = (i_ff == '0);
      status.i_eq_len     = (i_ff == len_ff);
      status.ev_hit       = ev_in_range && used_ff[ev_idx] && !evd_ff[ev_idx];
      status.out_free     = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // an evicted mark only stands on a used slot
   a_evd_used: assert property (@(posedge clock) disable iff (reset)
      (evd_ff & ~used_ff) == '0)
      else $error("evicted mark on unused slot");

   // the recency list never outgrows the slot table
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CNT_W'(LAYERS))
      else $error("recency length out of range");

   // an eviction commit only hits a resident used slot
   a_commit_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.ev_commit |-> (ev_in_range && used_ff[ev_idx] && !evd_ff[ev_idx]))
      else $error("eviction of a slot that is not resident");

   // an eviction report takes away from the resident total
   a_commit_total: assert property (@(posedge clock) disable iff (reset)
      cmd.ev_commit |=> (resident_ff == $past(resident_ff) - $past(size_ext)))
      else $error("resident total not reduced on eviction");

endmodule

### rtl/core/lru_byte_budget_evictor.sv
// ----------------------------------------------------------------------------
// lru_byte_budget_evictor
// LRU layer evictor with a byte budget: tracks layer slots, a recency list
// and resident/evicted totals, and evicts least recently used slots under
// memory pressure or on request.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | contents
//  req_    | in        | req_valid/req_stall | operation, slot, bytes, target
//  rsp_    | out       | rsp_valid/rsp_stall | eviction reports, final status
//  csr_    | in        | csr_valid/csr_ready | register index and data
//
//  One transaction at a time; each request is decoded and ends in a final
//  status. Unregister and access walk the recency memory with a read and a
//  write state per entry (access then shifts the list down the same way to
//  put the slot at the front); eviction visits list entries from the tail
//  through address, list, size and check states. The single read port of
//  the recency memory paces these walks. Reset is synchronous; memories need
//  no clearing pass. A stalled result holds the walk until it is taken.
// ----------------------------------------------------------------------------
module lru_byte_budget_evictor #(
   parameter int LAYERS    = 32,
   parameter int SIZE_BITS = 40
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lbe_pkg::lbe_req_type          req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lbe_pkg::lbe_rsp_type          rsp_payload,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lbe_pkg::TOT_W-1:0]     csr_data
);
   import lbe_pkg::*;

   lbe_cmd_type    cmd;
   lbe_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   lbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lbe_dp #(.LAYERS(LAYERS), .SIZE_BITS(SIZE_BITS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
